[sv/mted_pkg.sv]
package mted_pkg;

  // Tracker slots the configuration registers provide.
  localparam int NUM_SLOTS     = 4;
  localparam int NUM_SEQUENCES = 4;
  localparam int MAX_SEQ_LEN   = 8;
  localparam int SEQ_BYTES     = 8;
  localparam int LEN_W         = 4;
  localparam int CNT_W         = 3;
  localparam int IDX_W         = 3;
  localparam int CFG_W         = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SEQ0_BYTES = 3'd0;
  localparam logic [IDX_W-1:0] REG_SEQ0_LEN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SEQ1_BYTES = 3'd2;
  localparam logic [IDX_W-1:0] REG_SEQ1_LEN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SEQ2_BYTES = 3'd4;
  localparam logic [IDX_W-1:0] REG_SEQ2_LEN   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SEQ3_BYTES = 3'd6;
  localparam logic [IDX_W-1:0] REG_SEQ3_LEN   = 3'd7;

  typedef logic [7:0] byte_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    len_t             prog;
    logic             retired;
    logic             waiting;
    logic [CNT_W-1:0] bpm;
  } trk_t;

  typedef struct packed {
    logic             eol;
    len_t             len;
    logic [CNT_W-1:0] bpm;
  } res_t;

  // Lengths above the longest supported sequence are clipped to it.
  function automatic len_t eff_len(input len_t l);
    eff_len = (l > LEN_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN) : l;
  endfunction

endpackage

[sv/multi_terminator_line_end_detector.sv]
// A byte accepted on the input is held in the input register, and its result is
// loaded into the output register from there when the output register is empty or
// out_tready takes the result it holds. Throughput: one byte per cycle while
// out_tready stays high; the tracker update between them is combinational.
// Reset (rst_n low, synchronous) empties both registers, clears all trackers and
// loads the terminator registers with a single line feed as terminator 0.
module multi_terminator_line_end_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] end_of_line,
                                                    // [4:1] terminator_length,
                                                    // [7:5] bytes_after_terminator
  input  logic                          cfg_wen,
  input  logic [mted_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mted_pkg::CFG_W-1:0]    cfg_wdata
);
  import mted_pkg::*;

  logic [CFG_W-1:0]     seq_bytes_r [NUM_SLOTS];
  len_t                 seq_len_r   [NUM_SLOTS];
  trk_t                 trk_r       [NUM_SLOTS];
  trk_t                 trk1        [NUM_SLOTS];
  trk_t                 trk_nxt     [NUM_SLOTS];
  len_t                 len_eff     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] in_use;
  logic [NUM_SLOTS-1:0] hit;
  len_t                 best_r;
  len_t                 best_nxt;
  res_t                 res_nxt;
  res_t                 res_r;
  byte_t                in_byte_r;
  logic                 in_vld_r;
  logic                 out_vld_r;
  logic                 adv;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = !in_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.bpm, res_r.len, res_r.eol};

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_trk
    assign len_eff[i] = eff_len(seq_len_r[i]);
    assign in_use[i]  = (i < NUM_SEQUENCES) && (len_eff[i] != '0);

    mted_tracker u_trk (
      .st_i     (trk_r[i]),
      .in_use_i (in_use[i]),
      .len_i    (len_eff[i]),
      .seq_i    (seq_bytes_r[i]),
      .byte_i   (in_byte_r),
      .st_o     (trk1[i]),
      .hit_o    (hit[i])
    );
  end

  mted_decide u_dec (
    .st_i     (trk1),
    .in_use_i (in_use),
    .hit_i    (hit),
    .len_i    (len_eff),
    .best_i   (best_r),
    .st_o     (trk_nxt),
    .best_o   (best_nxt),
    .res_o    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      best_r    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        trk_r[i]       <= '0;
        seq_bytes_r[i] <= (i == 0) ? CFG_W'(8'h0a) : '0;
        seq_len_r[i]   <= (i == 0) ? LEN_W'(1) : '0;
      end
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_SEQ0_BYTES: seq_bytes_r[0] <= cfg_wdata;
          REG_SEQ0_LEN:   seq_len_r[0]   <= cfg_wdata[LEN_W-1:0];
          REG_SEQ1_BYTES: seq_bytes_r[1] <= cfg_wdata;
          REG_SEQ1_LEN:   seq_len_r[1]   <= cfg_wdata[LEN_W-1:0];
          REG_SEQ2_BYTES: seq_bytes_r[2] <= cfg_wdata;
          REG_SEQ2_LEN:   seq_len_r[2]   <= cfg_wdata[LEN_W-1:0];
          REG_SEQ3_BYTES: seq_bytes_r[3] <= cfg_wdata;
          REG_SEQ3_LEN:   seq_len_r[3]   <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      // Tracker state moves only when the held byte is handed to the output.
      if (in_vld_r && adv) begin
        trk_r  <= trk_nxt;
        best_r <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (in_vld_r && adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

[sv/mted_tracker.sv]
module mted_tracker (
  input  mted_pkg::trk_t            st_i,
  input  logic                      in_use_i,
  input  mted_pkg::len_t            len_i,
  input  logic [mted_pkg::CFG_W-1:0] seq_i,
  input  mted_pkg::byte_t           byte_i,
  output mted_pkg::trk_t            st_o,
  output logic                      hit_o
);
  import mted_pkg::*;

  byte_t seq_b [SEQ_BYTES];
  byte_t want;
  len_t  prog_inc;

  always_comb begin
    for (int k = 0; k < SEQ_BYTES; k++) begin
      seq_b[k] = seq_i[8*k +: 8];
    end
  end

  // Progress stays below the length here, so three bits select the byte.
  assign want     = seq_b[st_i.prog[2:0]];
  assign prog_inc = st_i.prog + 1'b1;

  always_comb begin
    st_o  = st_i;
    hit_o = 1'b0;
    if (in_use_i) begin
      if (st_i.retired) begin
        if (st_i.prog >= len_i && st_i.bpm != CNT_MAX) begin
          st_o.bpm = st_i.bpm + 1'b1;
        end
      end else if (st_i.prog >= len_i) begin
        st_o = '0;
      end else if (want == byte_i) begin
        st_o.prog = prog_inc;
        hit_o     = (prog_inc == len_i);
      end else if (!st_i.waiting) begin
        st_o = '0;
      end else begin
        // A waiting tracker that misses falls behind and leaves the race.
        st_o.retired = 1'b1;
        st_o.bpm     = '0;
      end
    end
  end

endmodule

[sv/mted_decide.sv]
module mted_decide (
  input  mted_pkg::trk_t                    st_i   [mted_pkg::NUM_SLOTS],
  input  logic [mted_pkg::NUM_SLOTS-1:0]    in_use_i,
  input  logic [mted_pkg::NUM_SLOTS-1:0]    hit_i,
  input  mted_pkg::len_t                    len_i  [mted_pkg::NUM_SLOTS],
  input  mted_pkg::len_t                    best_i,
  output mted_pkg::trk_t                    st_o   [mted_pkg::NUM_SLOTS],
  output mted_pkg::len_t                    best_o,
  output mted_pkg::res_t                    res_o
);
  import mted_pkg::*;

  len_t                 best1;
  trk_t                 st2 [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] matched;
  logic [NUM_SLOTS-1:0] active;
  logic                 pend;
  logic                 decide;
  logic                 found;

  always_comb begin
    best1 = best_i;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_i[i] && len_i[i] > best1) begin
        best1 = len_i[i];
      end
    end

    pend = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      st2[i]     = st_i[i];
      matched[i] = st_i[i].prog >= len_i[i];
      active[i]  = in_use_i[i] && !st_i[i].retired && !matched[i];
      if (|hit_i && in_use_i[i] && !st_i[i].retired) begin
        if (matched[i] || st_i[i].prog < best1) begin
          st2[i].retired = 1'b1;
          st2[i].bpm     = '0;
        end else begin
          st2[i].waiting = 1'b1;
          pend           = 1'b1;
        end
      end
    end

    // After a new match the race ends when nobody had to wait; otherwise it
    // ends when no tracker is still short of its sequence.
    decide = (|hit_i) ? !pend : !(|active);

    res_o = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (decide && !found && in_use_i[i] && matched[i] && st2[i].prog >= best1) begin
        res_o.eol = 1'b1;
        res_o.len = len_i[i];
        res_o.bpm = st2[i].bpm;
        found     = 1'b1;
      end
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      st_o[i] = decide ? '0 : st2[i];
    end
    best_o = decide ? '0 : best1;
  end

endmodule

[sv/mted_checker.sv]
module mted_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // The output register is empty right after a reset edge.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Without a line end, the length and the count read as zero.
  a_no_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == 7'd0)
    else $error("fields set without line end");

  // A reported terminator has a length between one and eight.
  a_eol_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[4:1] != 4'd0 && out_tdata[4:1] <= 4'd8)
    else $error("bad terminator length");

  // The input side is never blocked while the output register is free.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with free output");

endmodule

bind multi_terminator_line_end_detector mted_checker u_mted_checker (.*);
